// ===== rtl/core/kaf_pkg.sv =====
// kaf_pkg: shared constants, register indexes and state types for the
// kalman angle filter core. No dependencies.
package kaf_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 24;
    localparam int NOISE_WIDTH     = 24;
    localparam int SAMPLE_WIDTH    = 32;
    localparam int DIGIT_WIDTH     = 16;
    localparam int IN_DATA_WIDTH   = 88;
    localparam int OUT_DATA_WIDTH  = 96;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MEAS_NOISE  = 2'd2;

    localparam logic [NOISE_WIDTH-1:0] ANGLE_NOISE_RST = 24'd16777;
    localparam logic [NOISE_WIDTH-1:0] BIAS_NOISE_RST  = 24'd50332;
    localparam logic [NOISE_WIDTH-1:0] MEAS_NOISE_RST  = 24'd503316;

    typedef enum logic [1:0] {
        UNIT_IDLE,
        UNIT_RUN,
        UNIT_ROUND,
        UNIT_FINISH
    } kaf_unit_state_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,
        ST_DT_RATE,
        ST_DT_P11,
        ST_TEMP,
        ST_P00_PRED,
        ST_CROSS_01,
        ST_CROSS_10,
        ST_P11_PRED,
        ST_GAIN0,
        ST_GAIN1,
        ST_INNOV,
        ST_ANGLE,
        ST_BIAS,
        ST_UPD_P10,
        ST_UPD_P11,
        ST_UPD_P01,
        ST_UPD_P00,
        ST_OUT
    } kaf_seq_state_t;

endpackage

// ===== rtl/core/kalman_angle_filter_core.sv =====
// kalman_angle_filter_core: sequencer, state and stream ports over kaf_mul and kaf_div (kaf_pkg).
// Processing time is spent mostly in the serial divider, which does no division when P00 + R is zero.
// The core takes no new input while one is in progress; s_tready is high only in idle,
// and a result still waiting on m_tready holds the sequencer in its last step.
// Reset: rst_n async active low clears filter state and loads the default noise registers.
module kalman_angle_filter_core
    import kaf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // measured_angle [31:0], measured_rate [63:32], time_step [87:64]
    input  logic [IN_DATA_WIDTH-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // angle_estimate [31:0], corrected_rate [63:32], bias_estimate [95:64]
    output logic [OUT_DATA_WIDTH-1:0]  m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [NOISE_WIDTH-1:0]     cfg_data
);

    localparam int W  = VALUE_WIDTH;
    localparam int MW = VALUE_WIDTH + 1;
    localparam int SW = ((VALUE_WIDTH > SAMPLE_WIDTH) ? VALUE_WIDTH : SAMPLE_WIDTH) + 3;

    localparam logic signed [SW-1:0] HI_W  = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [SW-1:0] LO_W  = {{(SW - W + 1){1'b1}}, {(W - 1){1'b0}}};
    localparam logic signed [SW-1:0] HI_32 = {{(SW - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SW-1:0] LO_32 = {{(SW - 31){1'b1}}, {31{1'b0}}};

    function automatic logic signed [SW-1:0] sxw(input logic [W-1:0] v);
        return {{(SW - W){v[W-1]}}, v};
    endfunction

    function automatic logic signed [SW-1:0] sx32(input logic [SAMPLE_WIDTH-1:0] v);
        return {{(SW - SAMPLE_WIDTH){v[SAMPLE_WIDTH-1]}}, v};
    endfunction

    function automatic logic signed [SW-1:0] zx24(input logic [NOISE_WIDTH-1:0] v);
        return {{(SW - NOISE_WIDTH){1'b0}}, v};
    endfunction

    function automatic logic [W-1:0] sat_w(input logic signed [SW-1:0] v);
        logic [W-1:0] r;
        if (v > HI_W)
        begin
            r = HI_W[W-1:0];
        end
        else if (v < LO_W)
        begin
            r = LO_W[W-1:0];
        end
        else
        begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] sat_out(input logic [W-1:0] v);
        logic signed [SW-1:0] x;
        logic [SAMPLE_WIDTH-1:0] r;
        x = sxw(v);
        if (x > HI_32)
        begin
            r = HI_32[SAMPLE_WIDTH-1:0];
        end
        else if (x < LO_32)
        begin
            r = LO_32[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            r = x[SAMPLE_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic logic [MW-1:0] vx(input logic [W-1:0] v);
        return {v[W-1], v};
    endfunction

    function automatic logic [MW-1:0] ux(input logic [NOISE_WIDTH-1:0] v);
        return MW'(v);
    endfunction

    kaf_seq_state_t state_reg, state_next;

    logic [NOISE_WIDTH-1:0] noise_angle_reg, noise_bias_reg, noise_meas_reg;

    logic [W-1:0] ang_reg, ang_next;
    logic [W-1:0] bias_reg, bias_next;
    logic [W-1:0] p00_reg, p00_next;
    logic [W-1:0] p01_reg, p01_next;
    logic [W-1:0] p10_reg, p10_next;
    logic [W-1:0] p11_reg, p11_next;
    logic         started_reg, started_next;
    logic         out_valid_reg, out_valid_next;

    logic [W-1:0] rate_reg, rate_next;
    logic [W-1:0] tmp_reg, tmp_next;
    logic [W-1:0] mdb_reg, mdb_next;
    logic [W-1:0] k0_reg, k0_next;
    logic [W-1:0] k1_reg, k1_next;
    logic [W-1:0] y_reg, y_next;
    logic [SAMPLE_WIDTH-1:0] in_angle_reg, in_angle_next;
    logic [SAMPLE_WIDTH-1:0] in_rate_reg, in_rate_next;
    logic [NOISE_WIDTH-1:0]  dt_reg, dt_next;
    logic [SAMPLE_WIDTH-1:0] out_angle_reg, out_angle_next;
    logic [SAMPLE_WIDTH-1:0] out_rate_reg, out_rate_next;
    logic [SAMPLE_WIDTH-1:0] out_bias_reg, out_bias_next;

    logic          mul_start, mul_done;
    logic [MW-1:0] mul_a, mul_b;
    logic [W-1:0]  mul_result;
    logic          div_start, div_done;
    logic [W-1:0]  div_num;
    logic [W+1:0]  div_den;
    logic [W-1:0]  div_result;
    logic          out_free;

    kaf_mul #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .result (mul_result),
        .done   (mul_done)
    );

    kaf_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .result (div_result),
        .done   (div_done)
    );

    assign out_free  = !out_valid_reg || m_tready;
    // innovation variance, kept exact
    assign div_den   = {{2{p00_reg[W-1]}}, p00_reg} + (W + 2)'(noise_meas_reg);
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_bias_reg, out_rate_reg, out_angle_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_RATE;
            ST_RATE:     state_next = ST_DT_RATE;
            ST_DT_RATE:  if (mul_done) state_next = ST_DT_P11;
            ST_DT_P11:   if (mul_done) state_next = ST_TEMP;
            ST_TEMP:     state_next = ST_P00_PRED;
            ST_P00_PRED: if (mul_done) state_next = ST_CROSS_01;
            ST_CROSS_01: state_next = ST_CROSS_10;
            ST_CROSS_10: state_next = ST_P11_PRED;
            ST_P11_PRED: if (mul_done) state_next = ST_GAIN0;
            ST_GAIN0:    if (div_done) state_next = ST_GAIN1;
            ST_GAIN1:    if (div_done) state_next = ST_INNOV;
            ST_INNOV:    state_next = ST_ANGLE;
            ST_ANGLE:    if (mul_done) state_next = ST_BIAS;
            ST_BIAS:     if (mul_done) state_next = ST_UPD_P10;
            ST_UPD_P10:  if (mul_done) state_next = ST_UPD_P11;
            ST_UPD_P11:  if (mul_done) state_next = ST_UPD_P01;
            ST_UPD_P01:  if (mul_done) state_next = ST_UPD_P00;
            ST_UPD_P00:  if (mul_done) state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // unit control and register updates
    always_comb
    begin
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_num        = p00_reg;
        ang_next       = ang_reg;
        bias_next      = bias_reg;
        p00_next       = p00_reg;
        p01_next       = p01_reg;
        p10_next       = p10_reg;
        p11_next       = p11_reg;
        rate_next      = rate_reg;
        tmp_next       = tmp_reg;
        mdb_next       = mdb_reg;
        k0_next        = k0_reg;
        k1_next        = k1_reg;
        y_next         = y_reg;
        in_angle_next  = in_angle_reg;
        in_rate_next   = in_rate_reg;
        dt_next        = dt_reg;
        out_angle_next = out_angle_reg;
        out_rate_next  = out_rate_reg;
        out_bias_next  = out_bias_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    in_angle_next = s_tdata[31:0];
                    in_rate_next  = s_tdata[63:32];
                    dt_next       = s_tdata[87:64];
                end
            end
            ST_RATE:
            begin
                rate_next = sat_w(sx32(in_rate_reg) - sxw(bias_reg));
            end
            ST_DT_RATE:
            begin
                mul_a     = ux(dt_reg);
                mul_b     = vx(rate_reg);
                mul_start = !started_reg;
                if (mul_done) ang_next = sat_w(sxw(ang_reg) + sxw(mul_result));
            end
            ST_DT_P11:
            begin
                // dt * p11 is used three times in the prediction
                mul_a     = ux(dt_reg);
                mul_b     = vx(p11_reg);
                mul_start = !started_reg;
                if (mul_done) mdb_next = mul_result;
            end
            ST_TEMP:
            begin
                tmp_next = sat_w(sxw(mdb_reg) - sxw(p01_reg) - sxw(p10_reg)
                                 + zx24(noise_angle_reg));
            end
            ST_P00_PRED:
            begin
                mul_a     = ux(dt_reg);
                mul_b     = vx(tmp_reg);
                mul_start = !started_reg;
                if (mul_done) p00_next = sat_w(sxw(p00_reg) + sxw(mul_result));
            end
            ST_CROSS_01:
            begin
                p01_next = sat_w(sxw(p01_reg) - sxw(mdb_reg));
            end
            ST_CROSS_10:
            begin
                p10_next = sat_w(sxw(p10_reg) - sxw(mdb_reg));
            end
            ST_P11_PRED:
            begin
                mul_a     = ux(noise_bias_reg);
                mul_b     = ux(dt_reg);
                mul_start = !started_reg;
                if (mul_done) p11_next = sat_w(sxw(p11_reg) + sxw(mul_result));
            end
            ST_GAIN0:
            begin
                div_num   = p00_reg;
                div_start = !started_reg;
                if (div_done) k0_next = div_result;
            end
            ST_GAIN1:
            begin
                div_num   = p10_reg;
                div_start = !started_reg;
                if (div_done) k1_next = div_result;
            end
            ST_INNOV:
            begin
                y_next = sat_w(sx32(in_angle_reg) - sxw(ang_reg));
            end
            ST_ANGLE:
            begin
                mul_a     = vx(k0_reg);
                mul_b     = vx(y_reg);
                mul_start = !started_reg;
                if (mul_done) ang_next = sat_w(sxw(ang_reg) + sxw(mul_result));
            end
            ST_BIAS:
            begin
                mul_a     = vx(k1_reg);
                mul_b     = vx(y_reg);
                mul_start = !started_reg;
                if (mul_done) bias_next = sat_w(sxw(bias_reg) + sxw(mul_result));
            end
            // p10 and p11 first, while p00 and p01 still hold the predicted values
            ST_UPD_P10:
            begin
                mul_a     = vx(k1_reg);
                mul_b     = vx(p00_reg);
                mul_start = !started_reg;
                if (mul_done) p10_next = sat_w(sxw(p10_reg) - sxw(mul_result));
            end
            ST_UPD_P11:
            begin
                mul_a     = vx(k1_reg);
                mul_b     = vx(p01_reg);
                mul_start = !started_reg;
                if (mul_done) p11_next = sat_w(sxw(p11_reg) - sxw(mul_result));
            end
            ST_UPD_P01:
            begin
                mul_a     = vx(k0_reg);
                mul_b     = vx(p01_reg);
                mul_start = !started_reg;
                if (mul_done) p01_next = sat_w(sxw(p01_reg) - sxw(mul_result));
            end
            ST_UPD_P00:
            begin
                mul_a     = vx(k0_reg);
                mul_b     = vx(p00_reg);
                mul_start = !started_reg;
                if (mul_done) p00_next = sat_w(sxw(p00_reg) - sxw(mul_result));
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_angle_next = sat_out(ang_reg);
                    out_rate_next  = sat_out(rate_reg);
                    out_bias_next  = sat_out(bias_reg);
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase

        if (mul_start || div_start)
        begin
            started_next = 1'b1;
        end
        else if (mul_done || div_done)
        begin
            started_next = 1'b0;
        end
        else
        begin
            started_next = started_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            ang_reg       <= '0;
            bias_reg      <= '0;
            p00_reg       <= '0;
            p01_reg       <= '0;
            p10_reg       <= '0;
            p11_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
            ang_reg       <= ang_next;
            bias_reg      <= bias_next;
            p00_reg       <= p00_next;
            p01_reg       <= p01_next;
            p10_reg       <= p10_next;
            p11_reg       <= p11_next;
        end
    end

    // configuration transaction, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_angle_reg <= ANGLE_NOISE_RST;
            noise_bias_reg  <= BIAS_NOISE_RST;
            noise_meas_reg  <= MEAS_NOISE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ANGLE_NOISE: noise_angle_reg <= cfg_data;
                REG_BIAS_NOISE:  noise_bias_reg  <= cfg_data;
                REG_MEAS_NOISE:  noise_meas_reg  <= cfg_data;
                default:         noise_meas_reg  <= noise_meas_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg      <= rate_next;
        tmp_reg       <= tmp_next;
        mdb_reg       <= mdb_next;
        k0_reg        <= k0_next;
        k1_reg        <= k1_next;
        y_reg         <= y_next;
        in_angle_reg  <= in_angle_next;
        in_rate_reg   <= in_rate_next;
        dt_reg        <= dt_next;
        out_angle_reg <= out_angle_next;
        out_rate_reg  <= out_rate_next;
        out_bias_reg  <= out_bias_next;
    end

endmodule

// ===== rtl/core/kaf_mul.sv =====
// kaf_mul: shared fixed-point multiplier, one 16-bit digit of b per cycle,
// then round half away from zero at FRAC_BITS and saturate. Uses kaf_pkg.
module kaf_mul
    import kaf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH:0]   a,
    input  logic [VALUE_WIDTH:0]   b,
    output logic [VALUE_WIDTH-1:0] result,
    output logic                   done
);

    localparam int MW = VALUE_WIDTH + 1;
    localparam int ND = (MW + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
    localparam int BW = ND * DIGIT_WIDTH;
    localparam int AW = MW + BW;
    localparam int RW = AW - FRAC_BITS;
    localparam int CW = $clog2(ND);

    localparam logic [AW-1:0] HALF = AW'(1'b1) << (FRAC_BITS - 1);
    localparam logic [RW-1:0] LIM_POS =
        {{(RW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic [RW-1:0] LIM_NEG =
        {{(RW - VALUE_WIDTH){1'b0}}, 1'b1, {(VALUE_WIDTH - 1){1'b0}}};

    kaf_unit_state_t state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic [MW-1:0]          amag_reg, amag_next;
    logic [BW-1:0]          bsh_reg, bsh_next;
    logic [AW-1:0]          acc_reg, acc_next;
    logic [RW-1:0]          rnd_reg, rnd_next;
    logic [VALUE_WIDTH-1:0] result_reg, result_next;
    logic                   done_reg, done_next;

    logic [MW-1:0]          amag_in;
    logic [MW-1:0]          bmag_in;
    logic [DIGIT_WIDTH-1:0] digit;
    logic [MW+DIGIT_WIDTH-1:0] partial;
    logic [AW-1:0]          rsum;
    logic [RW-1:0]          mag;

    assign amag_in = a[MW-1] ? (~a + 1'b1) : a;
    assign bmag_in = b[MW-1] ? (~b + 1'b1) : b;
    assign digit   = bsh_reg[BW-1 -: DIGIT_WIDTH];
    assign partial = amag_reg * digit;
    assign rsum    = acc_reg + HALF;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            UNIT_IDLE:
            begin
                if (start)
                begin
                    state_next = UNIT_RUN;
                end
            end
            UNIT_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = UNIT_ROUND;
                end
            end
            UNIT_ROUND:  state_next = UNIT_FINISH;
            UNIT_FINISH: state_next = UNIT_IDLE;
            default:     state_next = UNIT_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        amag_next   = amag_reg;
        bsh_next    = bsh_reg;
        acc_next    = acc_reg;
        rnd_next    = rnd_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        mag         = '0;
        case (state_reg)
            UNIT_IDLE:
            begin
                if (start)
                begin
                    cnt_next  = CW'(ND - 1);
                    neg_next  = a[MW-1] ^ b[MW-1];
                    amag_next = amag_in;
                    bsh_next  = BW'(bmag_in);
                    acc_next  = '0;
                end
            end
            UNIT_RUN:
            begin
                // msb digit first, so the running sum shifts up one digit
                acc_next = (acc_reg << DIGIT_WIDTH) + AW'(partial);
                bsh_next = bsh_reg << DIGIT_WIDTH;
                cnt_next = cnt_reg - 1'b1;
            end
            UNIT_ROUND:
            begin
                rnd_next = rsum[AW-1:FRAC_BITS];
            end
            UNIT_FINISH:
            begin
                if (neg_reg)
                begin
                    mag         = (rnd_reg > LIM_NEG) ? LIM_NEG : rnd_reg;
                    result_next = ~mag[VALUE_WIDTH-1:0] + 1'b1;
                end
                else
                begin
                    mag         = (rnd_reg > LIM_POS) ? LIM_POS : rnd_reg;
                    result_next = mag[VALUE_WIDTH-1:0];
                end
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= UNIT_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        amag_reg   <= amag_next;
        bsh_reg    <= bsh_next;
        acc_reg    <= acc_next;
        rnd_reg    <= rnd_next;
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ===== rtl/core/kaf_div.sv =====
// kaf_div: shared restoring divider, one quotient bit per cycle, giving
// (num * 2^FRAC_BITS) / den truncated and saturated. Uses kaf_pkg.
module kaf_div
    import kaf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] num,
    input  logic [VALUE_WIDTH+1:0] den,
    output logic [VALUE_WIDTH-1:0] result,
    output logic                   done
);

    localparam int DW = VALUE_WIDTH + 2;
    localparam int QW = VALUE_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(QW);

    localparam logic [QW-1:0] LIM =
        {{(QW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};

    kaf_unit_state_t state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic [DW-1:0]          den_reg, den_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [QW-1:0]          quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] result_reg, result_next;
    logic                   done_reg, done_next;

    logic [VALUE_WIDTH-1:0] nmag;
    logic [DW-1:0]          dmag;
    logic [DW:0]            trial;
    logic [DW:0]            diff;
    logic                   ge;
    logic [QW-1:0]          mag;

    assign nmag  = num[VALUE_WIDTH-1] ? (~num + 1'b1) : num;
    assign dmag  = den[DW-1] ? (~den + 1'b1) : den;
    assign trial = {rem_reg, quo_reg[QW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});
    assign mag   = (quo_reg > LIM) ? LIM : quo_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            UNIT_IDLE:
            begin
                if (start)
                begin
                    state_next = (dmag == '0) ? UNIT_FINISH : UNIT_RUN;
                end
            end
            UNIT_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = UNIT_FINISH;
                end
            end
            UNIT_FINISH: state_next = UNIT_IDLE;
            default:     state_next = UNIT_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        case (state_reg)
            UNIT_IDLE:
            begin
                if (start)
                begin
                    cnt_next = CW'(QW - 1);
                    den_next = dmag;
                    rem_next = '0;
                    if (dmag == '0)
                    begin
                        // zero innovation variance gives zero gain
                        neg_next = 1'b0;
                        quo_next = '0;
                    end
                    else
                    begin
                        neg_next = num[VALUE_WIDTH-1] ^ den[DW-1];
                        quo_next = {nmag, {FRAC_BITS{1'b0}}};
                    end
                end
            end
            UNIT_RUN:
            begin
                rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
                quo_next = {quo_reg[QW-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end
            UNIT_FINISH:
            begin
                result_next = neg_reg ? (~mag[VALUE_WIDTH-1:0] + 1'b1)
                                      : mag[VALUE_WIDTH-1:0];
                done_next   = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= UNIT_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule
